// ----- hw/rtl/esd_pkg.sv -----
// package: constants and types for the eeg sync packet deframer
`timescale 1ns / 1ps

package esd_pkg;

	// packet layout
	localparam int CHANNELS       = 6;
	localparam int POS_W          = 5;
	localparam int CH_IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FIRST_CHAN_POS = 4;
	localparam int SWITCH_POS     = FIRST_CHAN_POS + 2 * CHANNELS;

	// sync pair
	localparam logic [7:0] SYNC_FIRST  = 8'hA5;
	localparam logic [7:0] SYNC_SECOND = 8'h5A;

	// lock phase, one-hot
	typedef enum logic [3:0] {
		PH_HUNT0 = 4'b0001,
		PH_HUNT1 = 4'b0010,
		PH_GOOD  = 4'b0100,
		PH_BAD   = 4'b1000
	} phase_t;

	typedef logic signed [15:0] chan_word_t;

endpackage

// ----- hw/rtl/esd_byte_if.sv -----
// interface: serial byte channel with valid/ready handshake
`timescale 1ns / 1ps

interface esd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hw/rtl/esd_result_if.sv -----
// interface: deframed packet result channel with valid/ready handshake
`timescale 1ns / 1ps

interface esd_result_if;
	logic                valid;
	logic                ready;
	logic signed [15:0]  chan0;
	logic signed [15:0]  chan1;
	logic signed [15:0]  chan2;
	logic signed [15:0]  chan3;
	logic signed [15:0]  chan4;
	logic signed [15:0]  chan5;
	logic [7:0]          switch_value;
	logic                switch_event;
	logic                sync_error;

	modport source (
		output valid, output chan0, output chan1, output chan2, output chan3,
		output chan4, output chan5, output switch_value, output switch_event,
		output sync_error, input ready
	);
	modport sink (
		input valid, input chan0, input chan1, input chan2, input chan3,
		input chan4, input chan5, input switch_value, input switch_event,
		input sync_error, output ready
	);
endinterface

// ----- hw/rtl/eeg_sync_packet_deframer.sv -----
// top level: frame sync hunt and fixed length packet deframer
// a byte is first registered in the input register, then processed into the result register
// throughput: one byte per cycle unless pkt stalls; one result per packet at its switch byte
// the input register advances whenever the result register is empty or being taken
// reset clears lock phase, byte position, high byte latch, last switch and valid flags at once
`timescale 1ns / 1ps

module eeg_sync_packet_deframer (
	input  logic                clk,
	input  logic                arst_n,
	esd_byte_if.sink            rx,
	esd_result_if.source        pkt
);

	// input register
	logic                        valid_s1;
	logic [7:0]                  byte_s1;

	// deframer state
	esd_pkg::phase_t             phase_q, phase_d;
	logic [esd_pkg::POS_W-1:0]   pos_q, pos_d;
	logic [7:0]                  hi_q, hi_d;
	logic [7:0]                  last_sw_q, last_sw_d;
	esd_pkg::chan_word_t         words_q [esd_pkg::CHANNELS];

	// result register
	logic                        out_valid_q;
	esd_pkg::chan_word_t         chan_out_q [esd_pkg::CHANNELS];
	logic [7:0]                  sw_out_q;
	logic                        sw_evt_q;
	logic                        sync_err_q;

	// processing controls
	logic                        advance;
	logic                        work;
	logic                        emit;
	logic                        emit_good;
	logic                        word_wr;
	logic [esd_pkg::POS_W-1:0]   rel;
	logic [esd_pkg::CH_IDX_W-1:0] word_idx;

	// handshake
	assign advance  = !out_valid_q || pkt.ready;
	assign work     = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	assign rel      = pos_q - esd_pkg::POS_W'(esd_pkg::FIRST_CHAN_POS);
	assign word_idx = rel[esd_pkg::CH_IDX_W:1];

	// next state for one byte
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		hi_d      = hi_q;
		last_sw_d = last_sw_q;
		word_wr   = 1'b0;
		emit      = 1'b0;
		emit_good = 1'b0;
		unique case (phase_q)
			esd_pkg::PH_HUNT0, esd_pkg::PH_HUNT1: begin
				if (byte_s1 == esd_pkg::SYNC_FIRST) begin
					phase_d = esd_pkg::PH_HUNT1;
				end else if (phase_q == esd_pkg::PH_HUNT1 &&
				             byte_s1 == esd_pkg::SYNC_SECOND) begin
					phase_d = esd_pkg::PH_GOOD;
					pos_d   = esd_pkg::POS_W'(2);
				end else begin
					phase_d = esd_pkg::PH_HUNT0;
				end
			end
			esd_pkg::PH_GOOD, esd_pkg::PH_BAD: begin
				// sync check and channel capture
				if (pos_q == '0) begin
					phase_d = (byte_s1 == esd_pkg::SYNC_FIRST) ? esd_pkg::PH_GOOD
					                                            : esd_pkg::PH_BAD;
				end else if (pos_q == esd_pkg::POS_W'(1)) begin
					if (byte_s1 != esd_pkg::SYNC_SECOND) begin
						phase_d = esd_pkg::PH_BAD;
					end
				end else if (pos_q >= esd_pkg::POS_W'(esd_pkg::FIRST_CHAN_POS) &&
				             pos_q <  esd_pkg::POS_W'(esd_pkg::SWITCH_POS)) begin
					if (!rel[0]) begin
						hi_d = byte_s1;
					end else begin
						word_wr = 1'b1;
					end
				end
				// packet end
				if (pos_q < esd_pkg::POS_W'(esd_pkg::SWITCH_POS)) begin
					pos_d = pos_q + esd_pkg::POS_W'(1);
				end else begin
					pos_d = '0;
					emit  = 1'b1;
					if (phase_q == esd_pkg::PH_BAD) begin
						phase_d = esd_pkg::PH_HUNT0;
					end else begin
						emit_good = 1'b1;
						last_sw_d = byte_s1;
					end
				end
			end
			default: begin
				phase_d = esd_pkg::PH_HUNT0;
			end
		endcase
	end

	// input register and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			phase_q   <= esd_pkg::PH_HUNT0;
			pos_q     <= '0;
			hi_q      <= '0;
			last_sw_q <= '0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (work) begin
				phase_q   <= phase_d;
				pos_q     <= pos_d;
				hi_q      <= hi_d;
				last_sw_q <= last_sw_d;
			end
		end
	end

	// input byte payload
	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// channel word store
	always_ff @(posedge clk) begin
		for (int k = 0; k < esd_pkg::CHANNELS; k++) begin
			if (work && word_wr && word_idx == esd_pkg::CH_IDX_W'(k)) begin
				words_q[k] <= {hi_q, byte_s1};
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= work && emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (work && emit) begin
			for (int k = 0; k < esd_pkg::CHANNELS; k++) begin
				chan_out_q[k] <= emit_good ? words_q[k] : '0;
			end
			sw_out_q   <= emit_good ? byte_s1 : 8'h00;
			sw_evt_q   <= emit_good && byte_s1 != last_sw_q && byte_s1 != 8'h00;
			sync_err_q <= !emit_good;
		end
	end

	assign pkt.valid        = out_valid_q;
	assign pkt.chan0        = chan_out_q[0];
	assign pkt.chan1        = chan_out_q[1];
	assign pkt.chan2        = chan_out_q[2];
	assign pkt.chan3        = chan_out_q[3];
	assign pkt.chan4        = chan_out_q[4];
	assign pkt.chan5        = chan_out_q[5];
	assign pkt.switch_value = sw_out_q;
	assign pkt.switch_event = sw_evt_q;
	assign pkt.sync_error   = sync_err_q;

endmodule

// ----- tb/testbench.sv -----
// testbench for the eeg sync packet deframer: directed and random byte streams
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 220;
	localparam int RANDOM_PACKETS = 10;

	typedef logic [esd_pkg::CHANNELS-1:0][15:0] word_vec_t;

	typedef struct packed {
		word_vec_t  chans;
		logic [7:0] sw;
		logic       ev;
		logic       err;
	} packet_result_t;

	logic clk;
	logic arst_n;

	esd_byte_if   rx_if ();
	esd_result_if pkt_if ();

	eeg_sync_packet_deframer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.pkt    (pkt_if)
	);

	// predictor state
	esd_pkg::phase_t lock_state;
	logic [4:0]  frame_pos;
	logic [7:0]  high_latch;
	word_vec_t   frame_words;
	logic [7:0]  prev_switch;

	packet_result_t expected_packets[$];
	int             predicted_count;
	int             error_count;
	int             cycle_count;
	int             bytes_sent;
	bit             idle_on;
	int             stall_left;
	logic [7:0]     last_switch_sent;

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("eeg_sync_packet_deframer verification failed");
			$finish;
		end
	end

	// predict one accepted byte, queue the packet it completes
	task automatic deframe_step(input logic [7:0] b);
		packet_result_t r;
		logic [4:0]     pos;
		int             rel;
		pos = frame_pos;
		if (lock_state == esd_pkg::PH_HUNT0 || lock_state == esd_pkg::PH_HUNT1) begin
			if (b == esd_pkg::SYNC_FIRST) begin
				lock_state = esd_pkg::PH_HUNT1;
			end else if (lock_state == esd_pkg::PH_HUNT1 && b == esd_pkg::SYNC_SECOND) begin
				// sync pair counts as bytes 0 and 1 of the first packet
				lock_state = esd_pkg::PH_GOOD;
				frame_pos = 5'd2;
			end else begin
				lock_state = esd_pkg::PH_HUNT0;
			end
		end else begin
			if (pos == 0) begin
				lock_state = (b == esd_pkg::SYNC_FIRST) ? esd_pkg::PH_GOOD : esd_pkg::PH_BAD;
			end else if (pos == 1) begin
				if (b != esd_pkg::SYNC_SECOND)
					lock_state = esd_pkg::PH_BAD;
			end else if (pos >= esd_pkg::FIRST_CHAN_POS && pos < esd_pkg::SWITCH_POS) begin
				rel = int'(pos) - esd_pkg::FIRST_CHAN_POS;
				if (rel % 2 == 0)
					high_latch = b;
				else
					frame_words[rel / 2] = {high_latch, b};
			end
			if (pos < esd_pkg::SWITCH_POS) begin
				frame_pos = pos + 5'd1;
			end else begin
				// switch byte closes the packet
				frame_pos = '0;
				r = '0;
				if (lock_state == esd_pkg::PH_BAD) begin
					r.err = 1'b1;
					lock_state = esd_pkg::PH_HUNT0;
				end else begin
					r.chans = frame_words;
					r.sw = b;
					r.ev = (b != prev_switch) && (b != 8'h00);
					prev_switch = b;
				end
				expected_packets.push_back(r);
				predicted_count++;
			end
		end
	endtask

	// send one byte, with an optional idle burst before it
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			rx_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		deframe_step(b);
		bytes_sent++;
	endtask

	// one full packet: sync pair, two ignored bytes, channel words, switch byte
	task automatic send_packet(input logic [7:0] s0, input logic [7:0] s1,
			input word_vec_t words, input logic [7:0] sw);
		send_byte(s0);
		send_byte(s1);
		send_byte(8'($urandom));
		send_byte(8'($urandom));
		for (int k = 0; k < esd_pkg::CHANNELS; k++) begin
			send_byte(words[k][15:8]);
			send_byte(words[k][7:0]);
		end
		send_byte(sw);
		last_switch_sent = sw;
	endtask

	function automatic word_vec_t random_words();
		word_vec_t w;
		for (int k = 0; k < esd_pkg::CHANNELS; k++) begin
			case ($urandom_range(0, 5))
				0:       w[k] = 16'h8000;
				1:       w[k] = 16'h7FFF;
				2:       w[k] = {esd_pkg::SYNC_FIRST, esd_pkg::SYNC_SECOND};
				default: w[k] = 16'($urandom);
			endcase
		end
		return w;
	endfunction

	// switch values biased toward repeats and zero
	function automatic logic [7:0] random_switch();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return last_switch_sent;
			2:       return 8'($urandom_range(1, 3));
			default: return 8'($urandom);
		endcase
	endfunction

	// result side ready with random stall bursts
	initial begin
		pkt_if.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 16);
			if (stall_left > 0) begin
				pkt_if.ready <= 1'b0;
				stall_left--;
			end else begin
				pkt_if.ready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expv, actv);
			error_count++;
		end
	endtask

	// compare each result transaction with the oldest expected packet
	always @(posedge clk) begin
		packet_result_t exp_r;
		word_vec_t      act_chans;
		if (arst_n && pkt_if.valid && pkt_if.ready) begin
			act_chans = {pkt_if.chan5, pkt_if.chan4, pkt_if.chan3,
				pkt_if.chan2, pkt_if.chan1, pkt_if.chan0};
			if (expected_packets.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual sync_error %0b sw %0d",
					$time, pkt_if.sync_error, pkt_if.switch_value);
				error_count++;
			end else begin
				exp_r = expected_packets.pop_front();
				for (int k = 0; k < esd_pkg::CHANNELS; k++)
					check_field($sformatf("chan%0d", k), $signed(exp_r.chans[k]),
						$signed(act_chans[k]));
				check_field("switch_value", exp_r.sw, pkt_if.switch_value);
				check_field("switch_event", exp_r.ev, pkt_if.switch_event);
				check_field("sync_error", exp_r.err, pkt_if.sync_error);
			end
		end
	end

	// hunting: noise, broken pairs, restart on a fresh first sync byte
	task automatic test_sync_hunt();
		logic [7:0] noise[8] = '{8'h00, 8'hFF, esd_pkg::SYNC_SECOND, esd_pkg::SYNC_FIRST,
			8'h00, esd_pkg::SYNC_SECOND, esd_pkg::SYNC_FIRST, esd_pkg::SYNC_FIRST};
		foreach (noise[i])
			send_byte(noise[i]);
		send_packet(esd_pkg::SYNC_FIRST, esd_pkg::SYNC_SECOND, random_words(), 8'h00);
	endtask

	// channel word extremes and sign handling
	task automatic test_channel_extremes();
		send_packet(esd_pkg::SYNC_FIRST, esd_pkg::SYNC_SECOND,
			{16'hFF00, 16'h0001, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000}, 8'h00);
		send_packet(esd_pkg::SYNC_FIRST, esd_pkg::SYNC_SECOND,
			{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h00FF, 16'h0100}, 8'hFF);
	endtask

	// switch events: repeat, change, change to zero
	task automatic test_switch_events();
		send_packet(esd_pkg::SYNC_FIRST, esd_pkg::SYNC_SECOND, random_words(), 8'hFF);
		send_packet(esd_pkg::SYNC_FIRST, esd_pkg::SYNC_SECOND, random_words(), 8'h01);
		send_packet(esd_pkg::SYNC_FIRST, esd_pkg::SYNC_SECOND, random_words(), 8'h00);
	endtask

	// bad first and second sync byte while locked, then regain lock
	task automatic test_sync_errors();
		send_packet(esd_pkg::SYNC_SECOND, esd_pkg::SYNC_SECOND, random_words(), 8'h33);
		send_packet(esd_pkg::SYNC_FIRST, esd_pkg::SYNC_SECOND, random_words(), 8'h10);
		send_packet(esd_pkg::SYNC_FIRST, esd_pkg::SYNC_FIRST, random_words(), 8'h44);
		// last switch survives the loss of lock
		send_packet(esd_pkg::SYNC_FIRST, esd_pkg::SYNC_SECOND, random_words(), 8'h10);
	endtask

	// mostly well-formed packets with random content, some corruption and noise
	task automatic test_random_stream();
		int start_bytes;
		int start_packets;
		int n;
		start_bytes = bytes_sent;
		start_packets = predicted_count;
		while (bytes_sent - start_bytes < RANDOM_BYTES ||
				predicted_count - start_packets < RANDOM_PACKETS) begin
			if ($urandom_range(0, 7) == 0)
				idle_on = !idle_on;
			case ($urandom_range(0, 9))
				0: send_packet(8'($urandom), esd_pkg::SYNC_SECOND, random_words(),
					random_switch());
				1: send_packet(esd_pkg::SYNC_FIRST, 8'($urandom), random_words(),
					random_switch());
				2: begin
					n = $urandom_range(1, 6);
					repeat (n) begin
						case ($urandom_range(0, 3))
							0:       send_byte(esd_pkg::SYNC_FIRST);
							1:       send_byte(esd_pkg::SYNC_SECOND);
							default: send_byte(8'($urandom));
						endcase
					end
				end
				default: send_packet(esd_pkg::SYNC_FIRST, esd_pkg::SYNC_SECOND,
					random_words(), random_switch());
			endcase
		end
		idle_on = 1'b1;
	endtask

	// back to back packets with no idling on either side
	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (4)
			send_packet(esd_pkg::SYNC_FIRST, esd_pkg::SYNC_SECOND, random_words(),
				random_switch());
	endtask

	initial begin
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = 8'h00;
		lock_state = esd_pkg::PH_HUNT0;
		frame_pos = '0;
		high_latch = '0;
		frame_words = '0;
		prev_switch = '0;
		predicted_count = 0;
		error_count = 0;
		cycle_count = 0;
		bytes_sent = 0;
		idle_on = 1'b1;
		last_switch_sent = 8'h00;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_sync_hunt();
		test_channel_extremes();
		test_switch_events();
		test_sync_errors();
		test_random_stream();
		test_back_to_back();

		@(negedge clk);
		rx_if.valid <= 1'b0;
		while (expected_packets.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("eeg_sync_packet_deframer verification clean");
		else
			$display("eeg_sync_packet_deframer verification failed");
		$finish;
	end

endmodule
